// ----- sv/hcks_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the divider step for the hue chroma keyer.
// No dependencies; every other file of the block uses this package.

package hcks_pkg;

    localparam int PixW      = 8;
    localparam int DivW      = 18;   // divider operand width
    localparam int QuoW      = 16;   // quotient bits per division
    localparam int DivStages = 8;
    localparam int DivSteps  = QuoW / DivStages;
    localparam int HueW      = 17;
    localparam int DistW     = 16;

    localparam logic [HueW-1:0] HueFull  = 17'd92160;  // 360 degrees
    localparam logic [HueW-1:0] HueHalf  = 17'd46080;  // 180 degrees
    localparam logic [HueW-1:0] HueGreen = 17'd30720;  // 120 degrees
    localparam logic [HueW-1:0] HueBlue  = 17'd61440;  // 240 degrees

    localparam logic [8:0]  KeyMax    = 9'd360;
    localparam logic [6:0]  PctMax    = 7'd100;
    localparam logic [8:0]  KeyReset  = 9'd120;
    localparam logic [6:0]  TolReset  = 7'd30;
    localparam logic [6:0]  SpillReset = 7'd50;
    localparam logic [8:0]  KeyGreenLo = 9'd60;
    localparam logic [8:0]  KeyGreenHi = 9'd180;
    localparam logic [8:0]  KeyBlueHi  = 9'd300;

    localparam logic [16:0] OneFix    = 17'd65536;
    localparam logic [25:0] Recip100  = 26'd42949673;  // ceil(2^32 / 100)
    localparam logic [11:0] TolScale  = 12'd2304;
    localparam logic [5:0]  HueScale  = 6'd60;

    typedef logic [1:0] t_reg_index;
    localparam t_reg_index RegKey   = 2'd0;
    localparam t_reg_index RegTol   = 2'd1;
    localparam t_reg_index RegSpill = 2'd2;

    typedef enum logic [1:0] {ChRed, ChGreen, ChBlue} t_chan;

    typedef struct packed {
        logic [PixW-1:0] blue;
        logic [PixW-1:0] green;
        logic [PixW-1:0] red;
        logic [PixW-1:0] alpha;
        logic            frame_end;
    } t_pix;

    typedef struct packed {
        t_pix  pix;
        t_chan chan;
        logic  neg;
        logic  keyed;
    } t_side;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [QuoW-1:0] q;
    } t_divst;

    // One restoring step of a fraction division (numerator below divisor).
    function automatic t_divst div_step(input t_divst s, input logic [DivW-1:0] den);
        logic [DivW:0] rem2;
        t_divst        o;
        rem2 = {s.rem, 1'b0};
        if (rem2 >= {1'b0, den}) begin
            o.rem = DivW'(rem2 - {1'b0, den});
            o.q   = {s.q[QuoW-2:0], 1'b1};
        end else begin
            o.rem = rem2[DivW-1:0];
            o.q   = {s.q[QuoW-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [PixW-1:0] min8(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PixW-1:0] max8(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- sv/hcks_div.sv -----
`timescale 1ns / 1ps
// Pipelined fraction divider: q = floor(num * 2^16 / den), two bits per stage.
// Depends on hcks_pkg; carries a t_side sideband alongside each item.

module hcks_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hcks_pkg::DivW-1:0]   i_num,
    input  logic [hcks_pkg::DivW-1:0]   i_den,
    input  hcks_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcks_pkg::QuoW-1:0]   o_q,
    output hcks_pkg::t_side             o_side
);

    localparam int Last = hcks_pkg::DivStages - 1;

    logic [hcks_pkg::DivStages-1:0] r_v;
    hcks_pkg::t_divst               r_st   [hcks_pkg::DivStages];
    logic [hcks_pkg::DivW-1:0]      r_den  [hcks_pkg::DivStages];
    hcks_pkg::t_side                r_side [hcks_pkg::DivStages];
    hcks_pkg::t_divst               n_st   [hcks_pkg::DivStages];
    logic [hcks_pkg::DivStages:0]   w_en;

    // A stage advances when it is empty or the next one advances.
    always_comb begin
        w_en[hcks_pkg::DivStages] = i_ready;
        for (int k = Last; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        hcks_pkg::t_divst s;
        s = '{rem: i_num, q: '0};
        for (int j = 0; j < hcks_pkg::DivSteps; j++) begin
            s = hcks_pkg::div_step(s, i_den);
        end
        n_st[0] = s;
        for (int k = 1; k < hcks_pkg::DivStages; k++) begin
            s = r_st[k-1];
            for (int j = 0; j < hcks_pkg::DivSteps; j++) begin
                s = hcks_pkg::div_step(s, r_den[k-1]);
            end
            n_st[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < hcks_pkg::DivStages; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_st[0]   <= n_st[0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
        for (int k = 1; k < hcks_pkg::DivStages; k++) begin
            if (w_en[k]) begin
                r_st[k]   <= n_st[k];
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[Last];
    assign o_q     = r_st[Last].q;
    assign o_side  = r_side[Last];

endmodule

// ----- sv/hcks_front.sv -----
`timescale 1ns / 1ps
// Input stage: channel max/min, HSV branch and hue divider operands.
// Depends on hcks_pkg.

module hcks_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  hcks_pkg::t_pix              i_pix,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcks_pkg::DivW-1:0]   o_num,
    output logic [hcks_pkg::DivW-1:0]   o_den,
    output hcks_pkg::t_side             o_side
);

    logic                       r_v;
    logic [hcks_pkg::DivW-1:0]  r_num;
    logic [hcks_pkg::DivW-1:0]  r_den;
    hcks_pkg::t_side            r_side;
    logic [hcks_pkg::DivW-1:0]  n_num;
    logic [hcks_pkg::DivW-1:0]  n_den;
    hcks_pkg::t_side            n_side;
    logic                       w_en;

    always_comb begin
        logic [7:0] cmax;
        logic [7:0] cmin;
        logic [7:0] delta;
        logic [7:0] mag;
        logic [8:0] diff;
        cmax  = hcks_pkg::max8(i_pix.red, hcks_pkg::max8(i_pix.green, i_pix.blue));
        cmin  = hcks_pkg::min8(i_pix.red, hcks_pkg::min8(i_pix.green, i_pix.blue));
        delta = cmax - cmin;
        n_side.pix = i_pix;
        priority if (cmax == i_pix.red) begin
            n_side.chan = hcks_pkg::ChRed;
            diff = {1'b0, i_pix.green} - {1'b0, i_pix.blue};
        end else if (cmax == i_pix.green) begin
            n_side.chan = hcks_pkg::ChGreen;
            diff = {1'b0, i_pix.blue} - {1'b0, i_pix.red};
        end else begin
            n_side.chan = hcks_pkg::ChBlue;
            diff = {1'b0, i_pix.red} - {1'b0, i_pix.green};
        end
        n_side.neg = diff[8];
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        // hue offset = 60*|n|/delta; scale the divisor by 64 so num < den
        n_num = hcks_pkg::DivW'(mag) * hcks_pkg::DivW'(hcks_pkg::HueScale);
        n_den = hcks_pkg::DivW'({delta, 6'b0});
        // saturation above 0.15
        n_side.keyed = (13'(delta) * 13'd20) > (13'(cmax) * 13'd3);
    end

    assign w_en = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ----- sv/hcks_dist.sv -----
`timescale 1ns / 1ps
// Hue assembly, circular distance to the key and window test (four stages).
// Depends on hcks_pkg; feeds the alpha factor divider.

module hcks_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [8:0]                  i_key,
    input  logic [6:0]                  i_tol,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hcks_pkg::QuoW-1:0]   i_q,
    input  hcks_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcks_pkg::DivW-1:0]   o_num,
    output logic [hcks_pkg::DivW-1:0]   o_den,
    output hcks_pkg::t_side             o_side
);

    logic [3:0]                 r_v;
    hcks_pkg::t_side            r_side [4];
    logic [hcks_pkg::HueW-1:0]  r_hue;
    logic [hcks_pkg::HueW-1:0]  r_ad;
    logic [hcks_pkg::DistW-1:0] r_d;
    logic [hcks_pkg::DivW-1:0]  r_num;
    logic [hcks_pkg::DivW-1:0]  r_den;
    logic [hcks_pkg::HueW-1:0]  n_hue;
    logic [hcks_pkg::HueW-1:0]  n_ad;
    logic [hcks_pkg::DistW-1:0] n_d;
    logic [hcks_pkg::DivW-1:0]  n_num;
    logic [hcks_pkg::DivW-1:0]  n_den;
    logic                       n_keyed;
    hcks_pkg::t_side            n_side3;
    logic [4:0]                 w_en;

    always_comb begin
        w_en[4] = i_ready;
        for (int k = 3; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    // Stage 0: base plus or minus the offset, wrapped into [0, 360).
    always_comb begin
        logic [hcks_pkg::HueW-1:0] mag;
        mag = hcks_pkg::HueW'(i_q[hcks_pkg::QuoW-1:2]);
        unique case (i_side.chan)
            hcks_pkg::ChRed: begin
                n_hue = (i_side.neg && mag != '0) ? hcks_pkg::HueFull - mag : mag;
            end
            hcks_pkg::ChGreen: begin
                n_hue = i_side.neg ? hcks_pkg::HueGreen - mag : hcks_pkg::HueGreen + mag;
            end
            hcks_pkg::ChBlue: begin
                n_hue = i_side.neg ? hcks_pkg::HueBlue - mag : hcks_pkg::HueBlue + mag;
            end
            default: begin
                n_hue = '0;
            end
        endcase
    end

    // Stage 1: absolute distance; stage 2: fold the long way round.
    always_comb begin
        logic [hcks_pkg::HueW-1:0] key_fix;
        key_fix = {i_key, 8'b0};
        n_ad = (r_hue >= key_fix) ? r_hue - key_fix : key_fix - r_hue;
        n_d  = (r_ad > hcks_pkg::HueHalf) ? hcks_pkg::DistW'(hcks_pkg::HueFull - r_ad)
                                          : r_ad[hcks_pkg::DistW-1:0];
    end

    // Stage 3: window test 5*d < 2304*tol and divider operands.
    always_comb begin
        n_num         = hcks_pkg::DivW'(r_d) * hcks_pkg::DivW'(5);
        n_den         = hcks_pkg::DivW'(i_tol) * hcks_pkg::DivW'(hcks_pkg::TolScale);
        n_keyed       = r_side[2].keyed && (n_num < n_den);
        n_side3       = r_side[2];
        n_side3.keyed = n_keyed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 4; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= i_side;
            r_hue     <= n_hue;
        end
        if (w_en[1]) begin
            r_side[1] <= r_side[0];
            r_ad      <= n_ad;
        end
        if (w_en[2]) begin
            r_side[2] <= r_side[1];
            r_d       <= n_d;
        end
        if (w_en[3]) begin
            r_side[3] <= n_side3;
            r_num     <= n_num;
            r_den     <= n_den;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side[3];

endmodule

// ----- sv/hcks_spill.sv -----
`timescale 1ns / 1ps
// Alpha scaling and spill suppression (four stages, last one is the output).
// Depends on hcks_pkg.

module hcks_spill (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [8:0]                  i_key,
    input  logic [6:0]                  i_spill,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hcks_pkg::QuoW-1:0]   i_q,
    input  hcks_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output hcks_pkg::t_pix              o_pix
);

    logic [3:0]              r_v;
    hcks_pkg::t_side         r_side [4];
    logic [22:0]             r_sfp;
    logic [16:0]             r_sf;
    logic [7:0]              r_c;
    logic signed [25:0]      r_prod;
    hcks_pkg::t_chan         r_chan;
    hcks_pkg::t_side         n_side0;
    hcks_pkg::t_pix          n_pix3;
    hcks_pkg::t_side         n_side3;
    logic [22:0]             n_sfp;
    logic [16:0]             n_sf;
    logic [7:0]              n_c;
    logic signed [25:0]      n_prod;
    hcks_pkg::t_chan         n_chan;
    logic [4:0]              w_en;

    always_comb begin
        w_en[4] = i_ready;
        for (int k = 3; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    // Stage 0: scale alpha, form spill * (1 - af).
    always_comb begin
        logic [23:0] aprod;
        aprod   = 24'(i_side.pix.alpha) * 24'(i_q);
        n_side0 = i_side;
        if (i_side.keyed) n_side0.pix.alpha = aprod[23:16];
        n_sfp = 23'(i_spill) * 23'(hcks_pkg::OneFix - 17'(i_q));
    end

    // Stage 1: divide by 100 through the reciprocal.
    always_comb begin
        logic [48:0] sfm;
        sfm  = 49'(r_sfp) * 49'(hcks_pkg::Recip100);
        n_sf = sfm[48:32];
    end

    // Stage 2: pick the key channel and its pull toward the lower neighbor.
    always_comb begin
        logic [7:0]         m;
        logic signed [17:0] sfs;
        logic signed [8:0]  dif;
        hcks_pkg::t_pix     p;
        p = r_side[1].pix;
        priority if (i_key >= hcks_pkg::KeyGreenLo && i_key <= hcks_pkg::KeyGreenHi) begin
            n_chan = hcks_pkg::ChGreen;
            n_c    = p.green;
            m      = hcks_pkg::min8(p.red, p.blue);
        end else if (i_key >= hcks_pkg::KeyGreenHi && i_key <= hcks_pkg::KeyBlueHi) begin
            n_chan = hcks_pkg::ChBlue;
            n_c    = p.blue;
            m      = hcks_pkg::min8(p.red, p.green);
        end else begin
            n_chan = hcks_pkg::ChRed;
            n_c    = p.red;
            m      = hcks_pkg::min8(p.green, p.blue);
        end
        sfs    = signed'({1'b0, r_sf});
        dif    = signed'({1'b0, n_c}) - signed'({1'b0, m});
        n_prod = 26'(sfs) * 26'(dif);
    end

    // Stage 3: C*65536 - sf*(C - m); the result always stays in 0..255.
    always_comb begin
        logic signed [25:0] v;
        v      = signed'({2'b0, r_c, 16'b0}) - r_prod;
        n_pix3 = r_side[2].pix;
        if (r_side[2].keyed) begin
            unique case (r_chan)
                hcks_pkg::ChGreen: n_pix3.green = v[23:16];
                hcks_pkg::ChBlue:  n_pix3.blue  = v[23:16];
                hcks_pkg::ChRed:   n_pix3.red   = v[23:16];
                default:           n_pix3.red   = r_side[2].pix.red;
            endcase
        end
        n_side3     = r_side[2];
        n_side3.pix = n_pix3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 4; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= n_side0;
            r_sfp     <= n_sfp;
        end
        if (w_en[1]) begin
            r_side[1] <= r_side[0];
            r_sf      <= n_sf;
        end
        if (w_en[2]) begin
            r_side[2] <= r_side[1];
            r_c       <= n_c;
            r_prod    <= n_prod;
            r_chan    <= n_chan;
        end
        if (w_en[3]) begin
            r_side[3] <= n_side3;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[3];
    assign o_pix   = r_side[3].pix;

`ifndef SYNTHESIS
    a_sf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> (r_sf <= hcks_pkg::OneFix))
        else $error("spill factor above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && !i_ready) |=> (r_v[3] && $stable(r_side[3].pix)))
        else $error("stalled result changed or dropped");
`endif

endmodule

// ----- sv/hue_chroma_key_with_spill.sv -----
`timescale 1ns / 1ps
// Top level of the HSV hue chroma keyer with spill suppression.
// Depends on hcks_pkg, hcks_front, hcks_div, hcks_dist and hcks_spill.
//
//  channel   dir  handshake                     payload
//  -------   ---  ----------------------------  ------------------------------------
//  pixel in  in   i_valid / o_ready             i_in_blue/green/red/alpha, frame_end
//  pixel out out  o_valid / i_ready             o_out_blue/green/red/alpha, frame_end
//  config    in   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item per clock while the output is not stalled; stages: 1 input stage, 8 hue divider
// stages, 4 distance stages, 8 alpha divider stages, 4 spill stages (last is output).
// Each stage fills when empty, so bubbles collapse while the output is stalled;
// o_ready drops only when every stage holds an item and i_ready is low.
// Synchronous active-low reset empties the pipeline and loads register defaults
// (key 120, tolerance 30, spill 50). Config is always accepted.

module hue_chroma_key_with_spill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_alpha,
    input  logic        i_frame_end_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_alpha,
    output logic        o_frame_end_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [8:0] r_key;
    logic [6:0] r_tol;
    logic [6:0] r_spill;
    logic [8:0] w_key;
    logic [6:0] w_tol;
    logic [6:0] w_spill;

    // Handshake wires between sections, named after the producer.
    logic                        w_fr_valid, w_fr_ready;
    logic [hcks_pkg::DivW-1:0]   w_fr_num, w_fr_den;
    hcks_pkg::t_side             w_fr_side;
    logic                        w_d1_valid, w_d1_ready;
    logic [hcks_pkg::QuoW-1:0]   w_d1_q;
    hcks_pkg::t_side             w_d1_side;
    logic                        w_ds_valid, w_ds_ready;
    logic [hcks_pkg::DivW-1:0]   w_ds_num, w_ds_den;
    hcks_pkg::t_side             w_ds_side;
    logic                        w_d2_valid, w_d2_ready;
    logic [hcks_pkg::QuoW-1:0]   w_d2_q;
    hcks_pkg::t_side             w_d2_side;
    hcks_pkg::t_pix              w_in_pix;
    hcks_pkg::t_pix              w_out_pix;

    // Config registers; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= hcks_pkg::KeyReset;
            r_tol   <= hcks_pkg::TolReset;
            r_spill <= hcks_pkg::SpillReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hcks_pkg::RegKey:   r_key   <= i_cfg_data;
                hcks_pkg::RegTol:   r_tol   <= i_cfg_data[6:0];
                hcks_pkg::RegSpill: r_spill <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Saturate out-of-range settings.
    assign w_key   = (r_key > hcks_pkg::KeyMax) ? hcks_pkg::KeyMax : r_key;
    assign w_tol   = (r_tol > hcks_pkg::PctMax) ? hcks_pkg::PctMax : r_tol;
    assign w_spill = (r_spill > hcks_pkg::PctMax) ? hcks_pkg::PctMax : r_spill;

    assign w_in_pix = '{blue: i_in_blue, green: i_in_green, red: i_in_red,
                        alpha: i_in_alpha, frame_end: i_frame_end_in};

    hcks_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (w_in_pix),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_num   (w_fr_num),
        .o_den   (w_fr_den),
        .o_side  (w_fr_side)
    );

    // Hue offset: 60*|n|/delta with 8 fraction bits (quotient / 4).
    hcks_div u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_num   (w_fr_num),
        .i_den   (w_fr_den),
        .i_side  (w_fr_side),
        .o_valid (w_d1_valid),
        .i_ready (w_d1_ready),
        .o_q     (w_d1_q),
        .o_side  (w_d1_side)
    );

    hcks_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (w_key),
        .i_tol   (w_tol),
        .i_valid (w_d1_valid),
        .o_ready (w_d1_ready),
        .i_q     (w_d1_q),
        .i_side  (w_d1_side),
        .o_valid (w_ds_valid),
        .i_ready (w_ds_ready),
        .o_num   (w_ds_num),
        .o_den   (w_ds_den),
        .o_side  (w_ds_side)
    );

    // Alpha factor: 5*d / (2304*tol) with 16 fraction bits.
    hcks_div u_alpha_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ds_valid),
        .o_ready (w_ds_ready),
        .i_num   (w_ds_num),
        .i_den   (w_ds_den),
        .i_side  (w_ds_side),
        .o_valid (w_d2_valid),
        .i_ready (w_d2_ready),
        .o_q     (w_d2_q),
        .o_side  (w_d2_side)
    );

    hcks_spill u_spill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (w_key),
        .i_spill (w_spill),
        .i_valid (w_d2_valid),
        .o_ready (w_d2_ready),
        .i_q     (w_d2_q),
        .i_side  (w_d2_side),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (w_out_pix)
    );

    assign o_out_blue      = w_out_pix.blue;
    assign o_out_green     = w_out_pix.green;
    assign o_out_red       = w_out_pix.red;
    assign o_out_alpha     = w_out_pix.alpha;
    assign o_frame_end_out = w_out_pix.frame_end;

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input blocked without a waiting item");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_out_blue, o_out_green,
            o_out_red, o_out_alpha, o_frame_end_out})))
        else $error("stalled result changed or dropped");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config write refused");
`endif

endmodule
